[hw/rtl/modular_exponentiation_assert.svh]
// assertion macros shared by the modular exponentiation rtl
// no dependencies; included by files that carry assertions
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MODEXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MODEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/modexp_pkg.sv]
// types and constants for the modular exponentiation block
// no dependencies
package modexp_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int RESULT_BITS = 31;
    localparam int STATUS_BITS = 2;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NEG_EXP   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SMALL_MOD = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REDUCE,
        S_STEP,
        S_MULACC,
        S_SQUARE,
        S_OUT
    } state_t;

endpackage

[hw/rtl/modexp_mulmod.sv]
// bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle
// requires a < m, b < 2^WIDTH, m < 2^(WIDTH-1); uses modexp_pkg-free plain logic
module modexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]    r_reg, r_next;
    logic [WIDTH-1:0]    a_reg;
    logic [WIDTH-1:0]    b_reg;
    logic [WIDTH-1:0]    m_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                done_reg;

    logic [WIDTH:0] dbl;
    logic [WIDTH:0] dbl_red;
    logic [WIDTH:0] sum;
    logic [WIDTH:0] m_ext;
    logic           running;

    assign running = (cnt_reg != '0);
    assign m_ext   = {1'b0, m_reg};

    // one step: r = 2r + bit * a, kept below m by conditional subtracts
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (b_reg[WIDTH-1] ? {1'b0, a_reg} : '0);
        r_next  = (sum >= m_ext) ? WIDTH'(sum - m_ext) : WIDTH'(sum);
    end

    // control: step counter and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= running && (cnt_reg == CNT_BITS'(1));
            if (go)
                cnt_reg <= CNT_BITS'(WIDTH);
            else if (running)
                cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    // datapath: operand load and serial shift of b
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            r_reg <= '0;
            a_reg <= a;
            b_reg <= b;
            m_reg <= m;
        end
        else if (running)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[hw/rtl/modular_exponentiation.sv]
// modular exponentiation top level: right-to-left square-and-multiply sequencer
// depends on modexp_pkg, modexp_mulmod and modular_exponentiation_assert.svh
//
//   channel  | handshake          | words
//   ---------+--------------------+-----------------------------------
//   command  | start, busy        | base_value, exponent, modulus
//   result   | done (1-cycle)     | power_result, status
//
// a word is taken when start is high and busy is low; busy stays high until
// the cycle after the done strobe. error and zero-exponent words go from decode
// straight to the result; otherwise the shared serial multiplier sets the time:
// one base reduction, then per exponent bit a step plus one or two products.
// reset clears the sequencer and the multiplier control only, not the datapath.
// the result is flagged by done for exactly one cycle.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
    parameter int WORD_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [modexp_pkg::FIELD_BITS-1:0]  base_value,
    input  logic signed [modexp_pkg::FIELD_BITS-1:0]  exponent,
    input  logic signed [modexp_pkg::FIELD_BITS-1:0]  modulus,
    output logic                                 done,
    output logic [modexp_pkg::RESULT_BITS-1:0]   power_result,
    output logic [modexp_pkg::STATUS_BITS-1:0]   status
);

    localparam int W = WORD_BITS;

    modexp_pkg::state_t state_reg, state_next;

    logic [W-1:0] base_reg;
    logic [W-1:0] exp_reg;
    logic [W-1:0] mod_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] sq_reg;
    logic [W-1:0] result_reg;
    logic [modexp_pkg::STATUS_BITS-1:0] status_reg;

    logic         accept;
    logic         base_neg;
    logic [W-1:0] base_mag;
    logic         exp_neg;
    logic         mod_bad;
    logic         exp_zero;
    logic         exp_one;

    logic         mm_go;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_done;
    logic [W-1:0] mm_result;

    assign accept = start && !busy;

    // decode of the stored words
    always_comb
    begin
        base_neg = base_reg[W-1];
        base_mag = base_neg ? (~base_reg + W'(1)) : base_reg;
        exp_neg  = exp_reg[W-1];
        mod_bad  = mod_reg[W-1] || (mod_reg[W-1:1] == '0);
        exp_zero = (exp_reg == '0);
        exp_one  = (exp_reg == W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::S_IDLE:
                if (accept)
                    state_next = modexp_pkg::S_DECODE;
            modexp_pkg::S_DECODE:
                if (exp_neg || mod_bad || exp_zero)
                    state_next = modexp_pkg::S_OUT;
                else
                    state_next = modexp_pkg::S_REDUCE;
            modexp_pkg::S_REDUCE:
                if (mm_done)
                    state_next = (mm_result == '0) ? modexp_pkg::S_OUT
                                                   : modexp_pkg::S_STEP;
            modexp_pkg::S_STEP:
                state_next = exp_reg[0] ? modexp_pkg::S_MULACC : modexp_pkg::S_SQUARE;
            modexp_pkg::S_MULACC:
                if (mm_done)
                    state_next = exp_one ? modexp_pkg::S_OUT : modexp_pkg::S_SQUARE;
            modexp_pkg::S_SQUARE:
                if (mm_done)
                    state_next = modexp_pkg::S_STEP;
            modexp_pkg::S_OUT:
                state_next = modexp_pkg::S_IDLE;
            default:
                state_next = modexp_pkg::S_IDLE;
        endcase
    end

    // outputs: multiplier launches and handshake
    always_comb
    begin
        mm_go = 1'b0;
        mm_a  = sq_reg;
        mm_b  = sq_reg;
        busy  = (state_reg != modexp_pkg::S_IDLE);
        done  = 1'b0;
        case (state_reg)
            modexp_pkg::S_DECODE:
            begin
                // base mod m computed as 1 * |base| mod m
                mm_go = !(exp_neg || mod_bad || exp_zero);
                mm_a  = W'(1);
                mm_b  = base_mag;
            end
            modexp_pkg::S_STEP:
            begin
                mm_go = 1'b1;
                if (exp_reg[0])
                    mm_a = acc_reg;
            end
            modexp_pkg::S_MULACC:
                mm_go = mm_done && !exp_one;
            modexp_pkg::S_OUT:
                done = 1'b1;
            default:
                mm_go = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= modexp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            modexp_pkg::S_IDLE:
                if (accept)
                begin
                    base_reg <= W'($unsigned(base_value));
                    exp_reg  <= W'($unsigned(exponent));
                    mod_reg  <= W'($unsigned(modulus));
                end
            modexp_pkg::S_DECODE:
            begin
                result_reg <= exp_zero ? W'(1) : '0;
                if (exp_neg)
                    status_reg <= modexp_pkg::ST_NEG_EXP;
                else if (mod_bad)
                    status_reg <= modexp_pkg::ST_SMALL_MOD;
                else
                begin
                    status_reg <= modexp_pkg::ST_OK;
                    if (exp_zero)
                        result_reg <= W'(1);
                end
                if (exp_neg || mod_bad)
                    result_reg <= '0;
            end
            modexp_pkg::S_REDUCE:
                if (mm_done)
                begin
                    acc_reg    <= W'(1);
                    result_reg <= '0;
                    sq_reg     <= (base_neg && (mm_result != '0)) ? (mod_reg - mm_result)
                                                                  : mm_result;
                end
            modexp_pkg::S_STEP:
                if (!exp_reg[0])
                    exp_reg <= exp_reg >> 1;
            modexp_pkg::S_MULACC:
                if (mm_done)
                begin
                    acc_reg    <= mm_result;
                    result_reg <= mm_result;
                    if (!exp_one)
                        exp_reg <= exp_reg >> 1;
                end
            modexp_pkg::S_SQUARE:
                if (mm_done)
                    sq_reg <= mm_result;
            default:
                result_reg <= result_reg;
        endcase
    end

    // shared serial multiplier
    modexp_mulmod #(
        .WIDTH (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mm_go),
        .a      (mm_a),
        .b      (mm_b),
        .m      (mod_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    assign power_result = modexp_pkg::RESULT_BITS'(result_reg);
    assign status       = status_reg;

    // checks
    `MODEXP_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy,
        "accepted word did not raise busy")
    `MODEXP_ASSERT_NOW(a_err_zero, clk, rst_n, done && (status != modexp_pkg::ST_OK),
        power_result == '0, "error result is not zero")
    `MODEXP_ASSERT_NOW(a_mm_done_state, clk, rst_n, mm_done,
        (state_reg == modexp_pkg::S_REDUCE) || (state_reg == modexp_pkg::S_MULACC)
        || (state_reg == modexp_pkg::S_SQUARE), "multiplier finished outside a wait state")
    `MODEXP_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy,
        "result strobe longer than one cycle")

endmodule

[test/modexp_checker.sv]
// checker for the modular exponentiation block: watches command and result words,
// predicts each power and status, and compares them in order
// depends on modexp_pkg
`timescale 1ns / 1ps

module modexp_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic                                      busy,
    input  logic signed [modexp_pkg::FIELD_BITS-1:0]  base_value,
    input  logic signed [modexp_pkg::FIELD_BITS-1:0]  exponent,
    input  logic signed [modexp_pkg::FIELD_BITS-1:0]  modulus,
    input  logic                                      done,
    input  logic [modexp_pkg::RESULT_BITS-1:0]        power_result,
    input  logic [modexp_pkg::STATUS_BITS-1:0]        status,
    output int                                        fail_count,
    output int                                        pending_words,
    output int                                        checked_words,
    output int                                        error_words,
    output int                                        zero_words
);

    // one expected result word, with the command that caused it
    typedef struct {
        logic signed [modexp_pkg::FIELD_BITS-1:0] b;
        logic signed [modexp_pkg::FIELD_BITS-1:0] e;
        logic signed [modexp_pkg::FIELD_BITS-1:0] m;
        logic [modexp_pkg::RESULT_BITS-1:0]       power;
        logic [modexp_pkg::STATUS_BITS-1:0]       st;
    } power_word_t;

    power_word_t expected_powers[$];

    initial
    begin
        fail_count    = 0;
        pending_words = 0;
        checked_words = 0;
        error_words   = 0;
        zero_words    = 0;
    end

    // square-and-multiply with exact 64-bit products
    function automatic void predict_power(
        input  logic signed [modexp_pkg::FIELD_BITS-1:0] b,
        input  logic signed [modexp_pkg::FIELD_BITS-1:0] e,
        input  logic signed [modexp_pkg::FIELD_BITS-1:0] m,
        output logic [modexp_pkg::RESULT_BITS-1:0]       power,
        output logic [modexp_pkg::STATUS_BITS-1:0]       st
    );
        logic [modexp_pkg::FIELD_BITS-1:0] base_mag;
        longint unsigned                   mod_u;
        longint unsigned                   exp_u;
        longint unsigned                   sq;
        longint unsigned                   acc;
        power = '0;
        st    = modexp_pkg::ST_OK;
        // negative exponent wins over a bad modulus
        if (e < 0)
            st = modexp_pkg::ST_NEG_EXP;
        else if (m < 2)
            st = modexp_pkg::ST_SMALL_MOD;
        else if (e == 0)
            power = 1;
        else
        begin
            base_mag = b[modexp_pkg::FIELD_BITS-1] ? (~b + 1'b1) : b;
            mod_u    = {32'd0, m};
            exp_u    = {32'd0, e};
            sq       = {32'd0, base_mag} % mod_u;
            if (sq != 0)
            begin
                // truncating remainder follows the base sign, lift it back up
                if (b[modexp_pkg::FIELD_BITS-1])
                    sq = mod_u - sq;
                acc = 1;
                while (exp_u != 0)
                begin
                    if ((exp_u & 1) != 0)
                        acc = (acc * sq) % mod_u;
                    exp_u = exp_u >> 1;
                    sq    = (sq * sq) % mod_u;
                end
                power = modexp_pkg::RESULT_BITS'(acc);
            end
        end
    endfunction

    // count a failure, show only the first few
    task automatic flag_mismatch(input string what, input power_word_t want,
                                 input logic [modexp_pkg::RESULT_BITS-1:0] got_power,
                                 input logic [modexp_pkg::STATUS_BITS-1:0] got_st);
        fail_count = fail_count + 1;
        if (fail_count <= 10)
            $display("%0t mismatch (%s): base %0d exp %0d mod %0d %s %0d status %0d, %s %0d status %0d",
                     $time, what, want.b, want.e, want.m,
                     "expected power", want.power, want.st,
                     "got power", got_power, got_st);
    endtask

    // sample both channels at each rising edge
    always @(posedge clk)
    begin : watch
        power_word_t w;
        if (rst_n)
        begin
            // command word accepted
            if (start && !busy)
            begin
                w.b = base_value;
                w.e = exponent;
                w.m = modulus;
                predict_power(base_value, exponent, modulus, w.power, w.st);
                expected_powers.push_back(w);
            end
            // result word
            if (done)
            begin
                if (expected_powers.size() == 0)
                begin
                    w = '{default: '0};
                    flag_mismatch("unexpected word", w, power_result, status);
                end
                else
                begin
                    w = expected_powers.pop_front();
                    checked_words = checked_words + 1;
                    if (w.st != modexp_pkg::ST_OK)
                        error_words = error_words + 1;
                    else if (w.power == 0)
                        zero_words = zero_words + 1;
                    if (power_result !== w.power)
                        flag_mismatch("power_result", w, power_result, status);
                    if (status !== w.st)
                        flag_mismatch("status", w, power_result, status);
                end
            end
            pending_words <= expected_powers.size();
        end
    end

endmodule

[test/tb_modular_exponentiation.sv]
// testbench top for modular_exponentiation: directed corner words, then random
// bursts of commands; checking is done by modexp_checker
// depends on modexp_pkg, modular_exponentiation and modexp_checker
`timescale 1ns / 1ps

module tb_modular_exponentiation;

    localparam int RANDOM_WORDS  = 268;
    localparam int SETTLE_CYCLES = 2200;

    logic                                     clk = 1'b0;
    logic                                     rst_n = 1'b0;
    logic                                     start = 1'b0;
    logic signed [modexp_pkg::FIELD_BITS-1:0] base_value = '0;
    logic signed [modexp_pkg::FIELD_BITS-1:0] exponent = '0;
    logic signed [modexp_pkg::FIELD_BITS-1:0] modulus = '0;
    logic                                     busy;
    logic                                     done;
    logic [modexp_pkg::RESULT_BITS-1:0]       power_result;
    logic [modexp_pkg::STATUS_BITS-1:0]       status;

    int fail_count;
    int pending_words;
    int checked_words;
    int error_words;
    int zero_words;
    int burst_left = 0;
    int sent_words = 0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    modular_exponentiation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .exponent     (exponent),
        .modulus      (modulus),
        .done         (done),
        .power_result (power_result),
        .status       (status)
    );

    modexp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .base_value    (base_value),
        .exponent      (exponent),
        .modulus       (modulus),
        .done          (done),
        .power_result  (power_result),
        .status        (status),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words),
        .error_words   (error_words),
        .zero_words    (zero_words)
    );

    // send one command word; a new burst may open with an idle gap
    task automatic send_word(input logic signed [modexp_pkg::FIELD_BITS-1:0] b,
                             input logic signed [modexp_pkg::FIELD_BITS-1:0] e,
                             input logic signed [modexp_pkg::FIELD_BITS-1:0] m);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(100, 2500);
                default: gap = $urandom_range(1, 40);
            endcase
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        start      <= 1'b1;
        base_value <= b;
        exponent   <= e;
        modulus    <= m;
        do @(posedge clk); while (busy);
        sent_words = sent_words + 1;
    endtask

    // hold off until every expected word has come back
    task automatic drain_words();
        start <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    // one random command word, mostly well-formed
    task automatic send_random_word();
        logic signed [modexp_pkg::FIELD_BITS-1:0] b;
        logic signed [modexp_pkg::FIELD_BITS-1:0] e;
        logic signed [modexp_pkg::FIELD_BITS-1:0] m;
        int                                       k;
        int                                       kind;
        b    = $urandom;
        e    = $urandom_range(0, 32'h7fffffff);
        m    = $urandom_range(2, 32'h7fffffff);
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            // valid words, modulus and exponent sizes mixed
            case ($urandom_range(0, 9))
                0, 1, 2, 3: m = $urandom_range(2, 1000);
                8, 9:       m = 32'h7fffffff - $urandom_range(0, 100);
                default:    ;
            endcase
            case ($urandom_range(0, 3))
                0:       e = $urandom_range(1, 64);
                1:       e = 32'h7fffffff - $urandom_range(0, 1000);
                default: ;
            endcase
        end
        else if (kind < 70)
            e = $urandom | 32'h80000000;
        else if (kind < 80)
        begin
            case ($urandom_range(0, 2))
                0:       m = 0;
                1:       m = 1;
                default: m = $urandom | 32'h80000000;
            endcase
            if ($urandom_range(0, 3) == 0)
                e = 0;
        end
        else if (kind < 90)
        begin
            if ($urandom_range(0, 1) == 0)
                e = 0;
            else
            begin
                // base a multiple of the modulus, either sign
                m = $urandom_range(2, 65535);
                k = int'($urandom_range(0, 60000)) - 30000;
                b = k * m;
            end
        end
        else
        begin
            e = $urandom;
            m = $urandom;
        end
        send_word(b, e, m);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: errors, zero exponent, zero base, signs, extremes
        send_word(5, 0, 7);
        send_word(0, 0, 13);
        send_word(3, -1, 7);
        send_word(32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_word(2, -5, 1);
        send_word(3, 5, 1);
        send_word(3, 5, 0);
        send_word(3, 5, -7);
        send_word(3, 5, 32'sh80000000);
        send_word(3, 0, 1);
        send_word(14, 5, 7);
        send_word(0, 9, 11);
        send_word(-21, 3, 7);
        send_word(-2, 5, 13);
        send_word(32'sh80000000, 3, 32'sh7fffffff);
        send_word(-1, 32'sh7fffffff, 32'sh7fffffff);
        send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_word(32'sh7ffffffe, 32'sh7fffffff, 32'sh7fffffff);
        send_word(123456789, 32'sh7fffffff, 2147483629);
        send_word(7, 100, 2);
        send_word(-3, 1, 2);
        send_word(-5, 1, 11);
        drain_words();

        // random bursts, with one full drain halfway
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain_words();
            send_random_word();
        end
        start <= 1'b0;

        // wait out the last results and any stray strobe
        do @(posedge clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d command words, checked %0d results", sent_words, checked_words);
        $display("results with error status: %0d, zero powers: %0d", error_words, zero_words);
        if (fail_count == 0 && pending_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending_words);
        $display("== FAIL ==");
        $finish;
    end

endmodule
